[design/obl_pkg.sv]
// Shared constants, operation codes and sequencer states of the ordered block list.
`default_nettype none

package obl_pkg;

    localparam int LIST_CAPACITY = 64;
    localparam int BLOCK_ID_BITS = 8;

    typedef enum logic [2:0] {
        OP_APPEND     = 3'd0,
        OP_PREPEND    = 3'd1,
        OP_REM_FIRST  = 3'd2,
        OP_REM_LAST   = 3'd3,
        OP_REM_BLOCK  = 3'd4,
        OP_MOVE_END   = 3'd5,
        OP_MOVE_FRONT = 3'd6,
        OP_CLEAR      = 3'd7
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,
        ST_UNL_DEC,
        ST_UNL_PREV,
        ST_UNL_NEXT,
        ST_INS_CHK,
        ST_INS_W1,
        ST_INS_W2,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

[design/ordered_block_list.sv]
// Ordered block list: doubly linked list of block numbers held in an entry RAM and a free pool RAM.
//
//  channel | signals                                               | direction
//  --------+-------------------------------------------------------+----------
//  in      | in_valid, in_stall, op, block                         | into block
//  out     | out_valid, out_stall, taken_block, taken_valid,       | out of block
//          | now_empty, entry_count, overflow                      |
//
// One word at a time. Remove-by-value and moves walk the list from the head, one entry RAM
// read a cycle; the single read port of the entry RAM sets the walk rate. Reset empties
// the list at once: the free pool is tracked against a high-water mark, so no clearing
// pass runs. A finished word waits in the output register while the next input word is
// accepted; an output stall holds the block only once the next word is done.
`default_nettype none

module ordered_block_list #(
    parameter int LIST_CAPACITY = obl_pkg::LIST_CAPACITY,
    parameter int BLOCK_ID_BITS = obl_pkg::BLOCK_ID_BITS,
    localparam int CNT_W = $clog2(LIST_CAPACITY + 1)
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [2:0]               op,
    input  wire logic [BLOCK_ID_BITS-1:0] block,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [BLOCK_ID_BITS-1:0]      taken_block,
    output logic                          taken_valid,
    output logic                          now_empty,
    output logic [CNT_W-1:0]              entry_count,
    output logic                          overflow
);

    localparam int IW = $clog2(LIST_CAPACITY);
    localparam int BW = BLOCK_ID_BITS;
    localparam int EW = BW + 2 * IW;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(LIST_CAPACITY);
    localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

    obl_pkg::state_t state_reg, state_next;
    obl_pkg::op_t    op_reg, op_next;
    obl_pkg::op_t    op_in;

    logic [BW-1:0]    blk_reg, blk_next;
    logic [IW-1:0]    head_reg, head_next;
    logic [IW-1:0]    tail_reg, tail_next;
    logic [IW-1:0]    cur_reg, cur_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [IW-1:0]    nx_reg, nx_next;
    logic [IW-1:0]    pv_reg, pv_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] hwm_reg, hwm_next;
    logic [CNT_W-1:0] walk_reg, walk_next;
    logic [BW-1:0]    res_block_reg, res_block_next;
    logic             res_taken_reg, res_taken_next;
    logic             res_ovf_reg, res_ovf_next;

    logic             out_valid_reg, out_valid_next;
    logic             load_out;
    logic [BW-1:0]    taken_block_reg;
    logic             taken_valid_reg;
    logic             now_empty_reg;
    logic [CNT_W-1:0] entry_count_reg;
    logic             overflow_reg;

    logic             ent_wr_en, ent_rd_en;
    logic [IW-1:0]    ent_wr_addr, ent_rd_addr;
    logic [EW-1:0]    ent_wr_data, ent_rd_data;
    logic             pool_wr_en, pool_rd_en;
    logic [IW-1:0]    pool_wr_addr, pool_rd_addr;
    logic [IW-1:0]    pool_wr_data, pool_rd_data;

    logic [BW-1:0]    rd_blk;
    logic [IW-1:0]    rd_next;
    logic [IW-1:0]    rd_prev;
    logic [CNT_W-1:0] take_wide;
    logic [CNT_W-1:0] free_wide;
    logic [CNT_W-1:0] count_inc;
    logic [IW-1:0]    slot_take;
    logic [IW-1:0]    slot_free;
    logic [IW-1:0]    new_idx;
    logic             in_accept;
    logic             tail_side;
    logic             is_move;
    logic             is_remove;

    // Entry word: block number, next link, previous link
    assign rd_blk  = ent_rd_data[EW-1 -: BW];
    assign rd_next = ent_rd_data[2*IW-1:IW];
    assign rd_prev = ent_rd_data[IW-1:0];

    // Free pool is a stack: take from slot CAPACITY-1-count, return to slot CAPACITY-count
    assign take_wide = CAP_C - ONE_C - count_reg;
    assign free_wide = CAP_C - count_reg;
    assign slot_take = take_wide[IW-1:0];
    assign slot_free = free_wide[IW-1:0];
    assign count_inc = count_reg + ONE_C;
    // Once the count reaches the high-water mark the slot was never written since clear, so its own number is used
    assign new_idx   = (hwm_reg > count_reg) ? pool_rd_data : slot_take;

    assign op_in     = obl_pkg::op_t'(op);
    assign in_stall  = (state_reg != obl_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign tail_side = (op_reg == obl_pkg::OP_APPEND) || (op_reg == obl_pkg::OP_MOVE_END);
    assign is_move   = (op_reg == obl_pkg::OP_MOVE_END) || (op_reg == obl_pkg::OP_MOVE_FRONT);
    assign is_remove = (op_reg == obl_pkg::OP_REM_FIRST) || (op_reg == obl_pkg::OP_REM_LAST)
                    || (op_reg == obl_pkg::OP_REM_BLOCK);

    obl_ram #(
        .WIDTH(EW),
        .DEPTH(LIST_CAPACITY)
    ) u_entry_ram (
        .clk    (clk),
        .wr_en  (ent_wr_en),
        .wr_addr(ent_wr_addr),
        .wr_data(ent_wr_data),
        .rd_en  (ent_rd_en),
        .rd_addr(ent_rd_addr),
        .rd_data(ent_rd_data)
    );

    obl_ram #(
        .WIDTH(IW),
        .DEPTH(LIST_CAPACITY)
    ) u_pool_ram (
        .clk    (clk),
        .wr_en  (pool_wr_en),
        .wr_addr(pool_wr_addr),
        .wr_data(pool_wr_data),
        .rd_en  (pool_rd_en),
        .rd_addr(pool_rd_addr),
        .rd_data(pool_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= obl_pkg::ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            hwm_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            hwm_reg       <= hwm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        blk_reg       <= blk_next;
        cur_reg       <= cur_next;
        idx_reg       <= idx_next;
        nx_reg        <= nx_next;
        pv_reg        <= pv_next;
        walk_reg      <= walk_next;
        res_block_reg <= res_block_next;
        res_taken_reg <= res_taken_next;
        res_ovf_reg   <= res_ovf_next;
        if (load_out)
        begin
            taken_block_reg <= res_block_reg;
            taken_valid_reg <= res_taken_reg;
            now_empty_reg   <= (count_reg == '0);
            entry_count_reg <= count_reg;
            overflow_reg    <= res_ovf_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        blk_next       = blk_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        nx_next        = nx_reg;
        pv_next        = pv_reg;
        count_next     = count_reg;
        hwm_next       = hwm_reg;
        walk_next      = walk_reg;
        res_block_next = res_block_reg;
        res_taken_next = res_taken_reg;
        res_ovf_next   = res_ovf_reg;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;

        ent_wr_en      = 1'b0;
        ent_wr_addr    = cur_reg;
        ent_wr_data    = ent_rd_data;
        ent_rd_en      = 1'b0;
        ent_rd_addr    = head_reg;
        pool_wr_en     = 1'b0;
        pool_wr_addr   = slot_free;
        pool_wr_data   = cur_reg;
        pool_rd_en     = 1'b0;
        pool_rd_addr   = slot_take;

        unique case (state_reg)
            obl_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next        = op_in;
                    blk_next       = block;
                    res_block_next = '0;
                    res_taken_next = 1'b0;
                    res_ovf_next   = 1'b0;
                    walk_next      = '0;
                    unique case (op_in)
                        obl_pkg::OP_APPEND, obl_pkg::OP_PREPEND:
                        begin
                            state_next = obl_pkg::ST_INS_CHK;
                        end
                        obl_pkg::OP_REM_FIRST, obl_pkg::OP_REM_LAST:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next = obl_pkg::ST_OUT;
                            end
                            else
                            begin
                                ent_rd_en   = 1'b1;
                                ent_rd_addr = (op_in == obl_pkg::OP_REM_FIRST) ? head_reg
                                                                               : tail_reg;
                                cur_next    = ent_rd_addr;
                                state_next  = obl_pkg::ST_UNL_DEC;
                            end
                        end
                        obl_pkg::OP_REM_BLOCK, obl_pkg::OP_MOVE_END, obl_pkg::OP_MOVE_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next = (op_in == obl_pkg::OP_REM_BLOCK)
                                           ? obl_pkg::ST_OUT : obl_pkg::ST_INS_CHK;
                            end
                            else
                            begin
                                ent_rd_en   = 1'b1;
                                ent_rd_addr = head_reg;
                                cur_next    = head_reg;
                                state_next  = obl_pkg::ST_FIND;
                            end
                        end
                        obl_pkg::OP_CLEAR:
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            count_next = '0;
                            hwm_next   = '0;
                            state_next = obl_pkg::ST_OUT;
                        end
                        default:
                        begin
                            state_next = obl_pkg::ST_OUT;
                        end
                    endcase
                end
            end

            obl_pkg::ST_FIND:
            begin
                // Compare one entry a cycle, following next links from the head
                if (rd_blk == blk_reg)
                begin
                    state_next = obl_pkg::ST_UNL_DEC;
                end
                else if (walk_reg == count_reg - ONE_C)
                begin
                    state_next = is_move ? obl_pkg::ST_INS_CHK : obl_pkg::ST_OUT;
                end
                else
                begin
                    ent_rd_en   = 1'b1;
                    ent_rd_addr = rd_next;
                    cur_next    = rd_next;
                    walk_next   = walk_reg + ONE_C;
                end
            end

            obl_pkg::ST_UNL_DEC:
            begin
                if (is_remove)
                begin
                    res_block_next = rd_blk;
                    res_taken_next = 1'b1;
                end
                pool_wr_en   = 1'b1;
                pool_wr_addr = slot_free;
                pool_wr_data = cur_reg;
                count_next   = count_reg - ONE_C;
                state_next   = is_move ? obl_pkg::ST_INS_CHK : obl_pkg::ST_OUT;
                priority if (count_reg == ONE_C)
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                else if (cur_reg == head_reg)
                begin
                    head_next = rd_next;
                end
                else if (cur_reg == tail_reg)
                begin
                    tail_next = rd_prev;
                end
                else
                begin
                    // Middle entry: relink both neighbours
                    nx_next     = rd_next;
                    pv_next     = rd_prev;
                    ent_rd_en   = 1'b1;
                    ent_rd_addr = rd_prev;
                    state_next  = obl_pkg::ST_UNL_PREV;
                end
            end

            obl_pkg::ST_UNL_PREV:
            begin
                ent_wr_en   = 1'b1;
                ent_wr_addr = pv_reg;
                ent_wr_data = {rd_blk, nx_reg, rd_prev};
                ent_rd_en   = 1'b1;
                ent_rd_addr = nx_reg;
                state_next  = obl_pkg::ST_UNL_NEXT;
            end

            obl_pkg::ST_UNL_NEXT:
            begin
                ent_wr_en   = 1'b1;
                ent_wr_addr = nx_reg;
                ent_wr_data = {rd_blk, rd_next, pv_reg};
                state_next  = is_move ? obl_pkg::ST_INS_CHK : obl_pkg::ST_OUT;
            end

            obl_pkg::ST_INS_CHK:
            begin
                if (count_reg == CAP_C)
                begin
                    res_ovf_next = 1'b1;
                    state_next   = obl_pkg::ST_OUT;
                end
                else
                begin
                    pool_rd_en   = 1'b1;
                    pool_rd_addr = slot_take;
                    ent_rd_en    = 1'b1;
                    ent_rd_addr  = tail_side ? tail_reg : head_reg;
                    state_next   = obl_pkg::ST_INS_W1;
                end
            end

            obl_pkg::ST_INS_W1:
            begin
                idx_next    = new_idx;
                ent_wr_en   = 1'b1;
                ent_wr_addr = new_idx;
                ent_wr_data = tail_side ? {blk_reg, {IW{1'b0}}, tail_reg}
                                        : {blk_reg, head_reg, {IW{1'b0}}};
                if (count_reg == '0)
                begin
                    head_next  = new_idx;
                    tail_next  = new_idx;
                    count_next = count_inc;
                    if (count_inc > hwm_reg)
                    begin
                        hwm_next = count_inc;
                    end
                    state_next = obl_pkg::ST_OUT;
                end
                else
                begin
                    state_next = obl_pkg::ST_INS_W2;
                end
            end

            obl_pkg::ST_INS_W2:
            begin
                // Point the old end entry at the new one; its word is still held
                ent_wr_en = 1'b1;
                if (tail_side)
                begin
                    ent_wr_addr = tail_reg;
                    ent_wr_data = {rd_blk, idx_reg, rd_prev};
                    tail_next   = idx_reg;
                end
                else
                begin
                    ent_wr_addr = head_reg;
                    ent_wr_data = {rd_blk, rd_next, idx_reg};
                    head_next   = idx_reg;
                end
                count_next = count_inc;
                if (count_inc > hwm_reg)
                begin
                    hwm_next = count_inc;
                end
                state_next = obl_pkg::ST_OUT;
            end

            obl_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = obl_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = obl_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign taken_block = taken_block_reg;
    assign taken_valid = taken_valid_reg;
    assign now_empty   = now_empty_reg;
    assign entry_count = entry_count_reg;
    assign overflow    = overflow_reg;

endmodule

`default_nettype wire

[design/obl_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered read data.
`default_nettype none

module obl_ram #(
    parameter int WIDTH = obl_pkg::BLOCK_ID_BITS,
    parameter int DEPTH = obl_pkg::LIST_CAPACITY,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold the last read word until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the ordered block list.
`timescale 1ns / 100ps

module tb;

    localparam int COUNT_BITS = $clog2(obl_pkg::LIST_CAPACITY + 1);
    localparam int RANDOM_ITEMS = 460;
    localparam int DRAIN_CYCLES = obl_pkg::LIST_CAPACITY + 20;
    localparam int IDLE_LIMIT = 5000;

    typedef logic [obl_pkg::BLOCK_ID_BITS-1:0] block_id_t;

    typedef struct packed {
        block_id_t             taken_block;
        logic                  taken_valid;
        logic                  now_empty;
        logic [COUNT_BITS-1:0] entry_count;
        logic                  overflow;
    } list_result_t;

    typedef enum int {
        PH_GROW,
        PH_DRAIN,
        PH_MIXED
    } traffic_phase_t;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY,
        STALL_LIGHT
    } stall_mode_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [2:0]            op = obl_pkg::OP_APPEND;
    block_id_t             block = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    block_id_t             taken_block;
    logic                  taken_valid;
    logic                  now_empty;
    logic [COUNT_BITS-1:0] entry_count;
    logic                  overflow;

    block_id_t    block_order[$];
    list_result_t pending_results[$];
    int           mismatch_count = 0;
    int           burst_left = 0;
    int           idle_cycles = 0;
    stall_mode_t  stall_mode = STALL_NONE;
    int           stall_left = 0;

    ordered_block_list dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .block       (block),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .taken_block (taken_block),
        .taken_valid (taken_valid),
        .now_empty   (now_empty),
        .entry_count (entry_count),
        .overflow    (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one operation to the expected block order and return the word it yields.
    function automatic list_result_t apply_list_op(obl_pkg::op_t code, block_id_t blk);
        list_result_t res;
        int           hit;
        res = '0;
        hit = -1;
        if (code == obl_pkg::OP_REM_BLOCK || code == obl_pkg::OP_MOVE_END
            || code == obl_pkg::OP_MOVE_FRONT)
        begin
            for (int i = 0; i < block_order.size(); i++)
            begin
                if (block_order[i] == blk)
                begin
                    hit = i;
                    break;
                end
            end
        end
        case (code)
            obl_pkg::OP_APPEND, obl_pkg::OP_PREPEND:
            begin
                if (block_order.size() >= obl_pkg::LIST_CAPACITY)
                    res.overflow = 1'b1;
                else if (code == obl_pkg::OP_APPEND)
                    block_order.push_back(blk);
                else
                    block_order.push_front(blk);
            end
            obl_pkg::OP_REM_FIRST, obl_pkg::OP_REM_LAST:
            begin
                if (block_order.size() > 0)
                begin
                    res.taken_valid = 1'b1;
                    if (code == obl_pkg::OP_REM_FIRST)
                        res.taken_block = block_order.pop_front();
                    else
                        res.taken_block = block_order.pop_back();
                end
            end
            obl_pkg::OP_REM_BLOCK:
            begin
                if (hit >= 0)
                begin
                    res.taken_valid = 1'b1;
                    res.taken_block = block_order[hit];
                    block_order.delete(hit);
                end
            end
            obl_pkg::OP_MOVE_END, obl_pkg::OP_MOVE_FRONT:
            begin
                // unlink first, so a block already held in a full list always fits again
                if (hit >= 0)
                    block_order.delete(hit);
                if (block_order.size() >= obl_pkg::LIST_CAPACITY)
                    res.overflow = 1'b1;
                else if (code == obl_pkg::OP_MOVE_END)
                    block_order.push_back(blk);
                else
                    block_order.push_front(blk);
            end
            default:
                block_order.delete();
        endcase
        res.now_empty = (block_order.size() == 0);
        res.entry_count = COUNT_BITS'(block_order.size());
        return res;
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Predict on each accepted input word, check each accepted result word.
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                pending_results.push_back(apply_list_op(obl_pkg::op_t'(op), block));
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result word with none expected: taken_block %0d taken_valid %0d",
                             $time, taken_block, taken_valid);
                    $display("%0t:   now_empty %0d entry_count %0d overflow %0d",
                             $time, now_empty, entry_count, overflow);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("taken_block", want.taken_block, taken_block);
                    compare_field("taken_valid", want.taken_valid, taken_valid);
                    compare_field("now_empty", want.now_empty, now_empty);
                    compare_field("entry_count", want.entry_count, entry_count);
                    compare_field("overflow", want.overflow, overflow);
                end
            end
        end
    end

    // Receiver back-pressure: switch between four stall patterns, each held for a random span.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(10, 60);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 1);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
            default:     out_stall <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Send one word; bursts of random length are mostly separated by random gaps.
    task automatic send_word(input obl_pkg::op_t code, input block_id_t blk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        op <= code;
        block <= blk;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    function automatic block_id_t pick_block();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return block_id_t'($urandom_range(0, 15));
        else if (roll == 6)
            return block_id_t'($urandom_range(240, 255));
        else
            return block_id_t'($urandom_range(0, 255));
    endfunction

    function automatic obl_pkg::op_t pick_op(traffic_phase_t phase);
        int roll;
        roll = $urandom_range(0, 99);
        case (phase)
            PH_GROW:
            begin
                if (roll < 35)      return obl_pkg::OP_APPEND;
                else if (roll < 55) return obl_pkg::OP_PREPEND;
                else if (roll < 67) return obl_pkg::OP_MOVE_END;
                else if (roll < 77) return obl_pkg::OP_MOVE_FRONT;
                else if (roll < 84) return obl_pkg::OP_REM_FIRST;
                else if (roll < 90) return obl_pkg::OP_REM_LAST;
                else                return obl_pkg::OP_REM_BLOCK;
            end
            PH_DRAIN:
            begin
                if (roll < 10)      return obl_pkg::OP_APPEND;
                else if (roll < 15) return obl_pkg::OP_PREPEND;
                else if (roll < 20) return obl_pkg::OP_MOVE_END;
                else if (roll < 25) return obl_pkg::OP_MOVE_FRONT;
                else if (roll < 50) return obl_pkg::OP_REM_FIRST;
                else if (roll < 70) return obl_pkg::OP_REM_LAST;
                else                return obl_pkg::OP_REM_BLOCK;
            end
            default:
            begin
                if (roll < 2)       return obl_pkg::OP_CLEAR;
                else if (roll < 20) return obl_pkg::OP_APPEND;
                else if (roll < 34) return obl_pkg::OP_PREPEND;
                else if (roll < 48) return obl_pkg::OP_MOVE_END;
                else if (roll < 62) return obl_pkg::OP_MOVE_FRONT;
                else if (roll < 74) return obl_pkg::OP_REM_FIRST;
                else if (roll < 86) return obl_pkg::OP_REM_LAST;
                else                return obl_pkg::OP_REM_BLOCK;
            end
        endcase
    endfunction

    task automatic test_empty_list();
        send_word(obl_pkg::OP_REM_FIRST, 8'd0);
        send_word(obl_pkg::OP_REM_LAST, 8'd255);
        send_word(obl_pkg::OP_REM_BLOCK, 8'd0);
        send_word(obl_pkg::OP_CLEAR, 8'd0);
    endtask

    task automatic test_each_operation();
        send_word(obl_pkg::OP_APPEND, 8'd0);
        send_word(obl_pkg::OP_PREPEND, 8'd255);
        send_word(obl_pkg::OP_APPEND, 8'd255);
        send_word(obl_pkg::OP_APPEND, 8'h5a);
        // duplicate: the copy nearest the head goes
        send_word(obl_pkg::OP_REM_BLOCK, 8'd255);
        send_word(obl_pkg::OP_REM_BLOCK, 8'd9);
        send_word(obl_pkg::OP_MOVE_END, 8'd0);
        send_word(obl_pkg::OP_MOVE_FRONT, 8'ha5);
        send_word(obl_pkg::OP_MOVE_FRONT, 8'h5a);
        send_word(obl_pkg::OP_PREPEND, 8'h80);
        send_word(obl_pkg::OP_REM_FIRST, 8'd0);
        send_word(obl_pkg::OP_REM_LAST, 8'd0);
        send_word(obl_pkg::OP_MOVE_END, 8'd255);
        send_word(obl_pkg::OP_CLEAR, 8'd255);
        send_word(obl_pkg::OP_APPEND, 8'd1);
        send_word(obl_pkg::OP_REM_LAST, 8'd0);
        send_word(obl_pkg::OP_REM_FIRST, 8'd0);
    endtask

    task automatic test_full_list();
        send_word(obl_pkg::OP_APPEND, 8'd77);
        repeat (obl_pkg::LIST_CAPACITY - 1)
            send_word($urandom_range(0, 1) ? obl_pkg::OP_APPEND : obl_pkg::OP_PREPEND,
                      block_id_t'($urandom_range(0, 15)));
        send_word(obl_pkg::OP_APPEND, 8'd255);
        send_word(obl_pkg::OP_PREPEND, 8'd0);
        send_word(obl_pkg::OP_MOVE_END, 8'd77);
        send_word(obl_pkg::OP_MOVE_FRONT, 8'd200);
        send_word(obl_pkg::OP_MOVE_FRONT, 8'd77);
        send_word(obl_pkg::OP_REM_BLOCK, 8'd77);
        send_word(obl_pkg::OP_APPEND, 8'd0);
        send_word(obl_pkg::OP_REM_LAST, 8'd0);
        send_word(obl_pkg::OP_REM_FIRST, 8'd0);
        send_word(obl_pkg::OP_CLEAR, 8'd0);
    endtask

    // Phases that favour inserts fill the list, drain phases empty it again.
    task automatic test_random_traffic();
        traffic_phase_t phase;
        int             phase_left;
        phase = PH_GROW;
        phase_left = 130;
        for (int sent = 0; sent < RANDOM_ITEMS; sent++)
        begin
            if (phase_left == 0)
            begin
                phase = traffic_phase_t'($urandom_range(0, 2));
                phase_left = $urandom_range(30, 140);
            end
            send_word(pick_op(phase), pick_block());
            phase_left--;
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_each_operation();
        test_full_list();
        test_random_traffic();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
